@@ rtl/core/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-k select package
// Shared constants, outcome codes, controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none
package tks_pkg;
  localparam int MaxKeep = 16;
  localparam int KeepW   = 5;
  localparam int IdxW    = 4;
  localparam int PosW    = 16;
  localparam int CntW    = 17;
  localparam logic [CntW-1:0] MaxRow = 17'd65536;

  localparam logic [1:0] OUT_OK    = 2'd0;
  localparam logic [1:0] OUT_SHORT = 2'd1;
  localparam logic [1:0] OUT_LONG  = 2'd2;

  localparam logic CFG_KEEP   = 1'b0;
  localparam logic CFG_FORMAT = 1'b1;

  typedef struct packed {
    logic           insert;   // insert value into chain
    logic [31:0]    bits;
    logic           clear;    // clear row state
    logic [IdxW-1:0] rd_idx;  // entry to present
  } dp_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [31:0]     rd_bits;
    logic [PosW-1:0] rd_pos;
  } dp_sts_t;

  function automatic logic [31:0] rank_of(input logic [31:0] bits, input logic fmt);
    logic [31:0] f;
    f = fmt ? {bits[15:0], 16'h0} : bits;
    if (f[30:23] == 8'hFF && f[22:0] != 23'h0) begin
      rank_of = 32'h0;
    end else if (f == 32'h8000_0000) begin
      rank_of = 32'h8000_0000;
    end else if (f[31]) begin
      rank_of = ~f;
    end else begin
      rank_of = f | 32'h8000_0000;
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/tks_datapath.sv @@
// ----------------------------------------------------------------------------
// Top-k select datapath
// Sorted register chain with parallel insertion, row position counter.
// ----------------------------------------------------------------------------
`default_nettype none
module tks_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fmt,
  input  wire tks_pkg::dp_cmd_t cmd,
  output tks_pkg::dp_sts_t      sts
);
  import tks_pkg::*;

  logic [31:0]     val_r [MaxKeep];
  logic [PosW-1:0] pos_r [MaxKeep];
  logic [MaxKeep-1:0] vld_r;
  logic [CntW-1:0] cnt_r;
  logic [MaxKeep-1:0] take;
  logic [MaxKeep-1:0] below;
  logic [31:0] rnk;

  // below[i]: the insertion slot lies at a lower index, so entry i shifts
  always_comb begin
    rnk = rank_of(cmd.bits, fmt);
    for (int i = 0; i < MaxKeep; i++) begin
      take[i] = !vld_r[i] || (rank_of(val_r[i], fmt) < rnk);
    end
    below[0] = 1'b0;
    for (int i = 1; i < MaxKeep; i++) begin
      below[i] = below[i-1] | take[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vld_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < MaxKeep; i++) begin
        val_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (cmd.insert) begin
      if (cnt_r < MaxRow) begin
        for (int i = 0; i < MaxKeep; i++) begin
          if (below[i]) begin
            val_r[i] <= val_r[(i == 0) ? 0 : i-1];
            pos_r[i] <= pos_r[(i == 0) ? 0 : i-1];
            vld_r[i] <= vld_r[(i == 0) ? 0 : i-1];
          end else if (take[i]) begin
            val_r[i] <= cmd.bits;
            pos_r[i] <= cnt_r[PosW-1:0];
            vld_r[i] <= 1'b1;
          end
        end
      end
      if (cnt_r <= MaxRow) cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.count   = cnt_r;
  assign sts.rd_bits = val_r[cmd.rd_idx];
  assign sts.rd_pos  = pos_r[cmd.rd_idx];
endmodule
`default_nettype wire

@@ rtl/core/tks_ctrl.sv @@
// ----------------------------------------------------------------------------
// Top-k select controller
// Accepts values, drives insertion, sequences the k results at row end.
// ----------------------------------------------------------------------------
`default_nettype none
module tks_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fmt,
  input  wire logic [tks_pkg::KeepW-1:0] keep,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [31:0]               in_bits,
  input  wire logic                      in_last,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [31:0]                    out_bits,
  output logic [tks_pkg::PosW-1:0]       out_pos,
  output logic [1:0]                     out_code,
  output logic                           out_last,
  output tks_pkg::dp_cmd_t               cmd,
  input  wire tks_pkg::dp_sts_t          sts
);
  import tks_pkg::*;

  typedef enum logic [1:0] {S_RUN, S_CHECK, S_EMIT, S_WAIT} state_t;

  state_t          state_r;
  logic [IdxW-1:0] idx_r;
  logic [KeepW-1:0] k_r;
  logic            ovld_r;
  logic [31:0]     obits_r;
  logic [PosW-1:0] opos_r;
  logic [1:0]      ocode_r;
  logic            olast_r;
  logic            acc;
  logic            ofree;
  logic [KeepW-1:0] k_eff;
  logic [31:0]     wbits;
  logic            bad;
  logic            load;

  assign ofree     = !ovld_r || out_tready;
  assign in_tready = (state_r == S_RUN);
  assign acc       = in_tvalid && in_tready;
  assign wbits     = fmt ? {16'h0, in_bits[15:0]} : in_bits;
  assign k_eff     = (keep == '0) ? KeepW'(1) :
                     (keep > KeepW'(MaxKeep)) ? KeepW'(MaxKeep) : keep;
  assign bad       = ({12'h0, k_r} > sts.count) || (sts.count > MaxRow);
  assign load      = ofree && (((state_r == S_CHECK) && bad) || (state_r == S_EMIT));

  always_comb begin
    cmd.insert = acc;
    cmd.bits   = wbits;
    cmd.clear  = (state_r == S_WAIT) && ofree;
    cmd.rd_idx = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      idx_r   <= '0;
      k_r     <= KeepW'(1);
      ovld_r  <= 1'b0;
    end else begin
      ovld_r <= load || (ovld_r && !out_tready);
      case (state_r)
        S_RUN: begin
          if (acc && in_last) begin
            state_r <= S_CHECK;
            k_r     <= k_eff;
            idx_r   <= '0;
          end
        end
        S_CHECK: begin
          if (ofree) begin
            if (bad) begin
              obits_r <= '0;
              opos_r  <= '0;
              ocode_r <= ({12'h0, k_r} > sts.count) ? OUT_SHORT : OUT_LONG;
              olast_r <= 1'b1;
              state_r <= S_WAIT;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (ofree) begin
            obits_r <= sts.rd_bits;
            opos_r  <= sts.rd_pos;
            ocode_r <= OUT_OK;
            olast_r <= ({1'b0, idx_r} + 1'b1 == k_r);
            idx_r   <= idx_r + 1'b1;
            if ({1'b0, idx_r} + 1'b1 == k_r) state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (ofree) state_r <= S_RUN;
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_tvalid = ovld_r;
  assign out_bits   = obits_r;
  assign out_pos    = opos_r;
  assign out_code   = ocode_r;
  assign out_last   = olast_r;
endmodule
`default_nettype wire

@@ rtl/core/streaming_top_k_select_core.sv @@
// ----------------------------------------------------------------------------
// Streaming top-k select core
// Keeps the k largest values of each row with their positions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one value per transaction, in_tlast marks the row's last value.
//   out_* : k results per row, best first, out_tlast on the last; a row
//           shorter than k or longer than 65536 gives one error result.
//   cfg_* : write keep_count (index 0) and value_format (index 1) when idle.
// Throughput: one value per cycle inside a row; the insertion into the
//   16-entry sorted register chain completes in the accepting cycle.
// Row end: the input stalls while the core checks the row, emits its results
//   and clears the chain, and stalls longer while out_tready is low.
// First result: loaded by the check state on error, else by the emit state.
// Reset: chain empty, keep_count 1, float32 format. A stalled receiver holds
//   the output register and freezes the result sequence.
// ----------------------------------------------------------------------------
`default_nettype none
module streaming_top_k_select_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // sample_bits
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // best_bits, best_position, outcome, pad
  output logic             out_tlast
);
  import tks_pkg::*;

  logic [KeepW-1:0] keep_r;
  logic             fmt_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [31:0]      ob;
  logic [PosW-1:0]  op;
  logic [1:0]       oc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KeepW'(1);
      fmt_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEEP) keep_r <= cfg_data;
      else if (cfg_index == CFG_FORMAT) fmt_r <= cfg_data[0];
    end
  end

  tks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .fmt(fmt_r), .keep(keep_r),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_bits(in_tdata),
    .in_last(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_bits(ob), .out_pos(op), .out_code(oc), .out_last(out_tlast),
    .cmd(cmd), .sts(sts)
  );

  tks_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .fmt(fmt_r), .cmd(cmd), .sts(sts)
  );

  assign out_tdata = {6'h0, oc, op, ob};
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Top-k select core testbench
// Streams rows of float32 and bfloat16 values through the core and checks
// every result against an in-bench ranking chain. The rows cover ties, signed
// zeros, NaNs, infinities, short rows and keep_count extremes, with random
// idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import tks_pkg::*;

  localparam int WatchLimit = 4000;

  typedef struct {
    logic [31:0] bits;
    logic        last;
  } sample_t;

  typedef struct {
    logic [31:0]     bits;
    logic [PosW-1:0] pos;
    logic [1:0]      outcome;
    logic            last;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // sample_bits
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // best_bits, best_position, outcome, pad
  logic        out_tlast;

  streaming_top_k_select_core dut (.*);

  always #6 clk = ~clk;

  sample_t     row_queue[$];
  pick_t       pick_queue[$];
  int          errors = 0;
  int          send_idle = 17;
  int          recv_idle = 58;
  logic        in_acc = 1'b0;
  int          quiet = 0;

  logic [31:0]     chain_bits[MaxKeep];
  logic [PosW-1:0] chain_pos[MaxKeep];
  logic            chain_full[MaxKeep];
  int              row_count;
  logic [4:0]      keep_reg;
  logic            fmt_reg;

  function automatic logic [31:0] order_key(logic [31:0] b, logic fmt);
    logic [31:0] f;
    f = fmt ? {b[15:0], 16'h0} : b;
    if (f[30:23] == 8'hFF && f[22:0] != 0) return 32'h0;
    if (f == 32'h8000_0000) f = 32'h0;
    if (f[31]) return ~f;
    return f | 32'h8000_0000;
  endfunction

  task automatic clear_chain();
    for (int i = 0; i < MaxKeep; i++) begin
      chain_bits[i] = '0;
      chain_pos[i] = '0;
      chain_full[i] = 1'b0;
    end
    row_count = 0;
  endtask

  task automatic rank_sample(logic [31:0] raw, logic last);
    logic [31:0] b;
    int slot;
    int k;
    pick_t p;
    b = fmt_reg ? {16'h0, raw[15:0]} : raw;
    if (row_count < 65536) begin
      slot = MaxKeep;
      for (int i = 0; i < MaxKeep; i++)
        if (slot == MaxKeep && (!chain_full[i] ||
            order_key(chain_bits[i], fmt_reg) < order_key(b, fmt_reg)))
          slot = i;
      if (slot < MaxKeep) begin
        for (int i = MaxKeep - 1; i > slot; i--) begin
          chain_bits[i] = chain_bits[i-1];
          chain_pos[i] = chain_pos[i-1];
          chain_full[i] = chain_full[i-1];
        end
        chain_bits[slot] = b;
        chain_pos[slot] = row_count[PosW-1:0];
        chain_full[slot] = 1'b1;
      end
    end
    if (row_count <= 65536) row_count++;
    if (!last) return;
    k = keep_reg == 0 ? 1 : (keep_reg > MaxKeep ? MaxKeep : keep_reg);
    if (row_count < k || row_count > 65536) begin
      p.bits = '0;
      p.pos = '0;
      p.outcome = row_count < k ? OUT_SHORT : OUT_LONG;
      p.last = 1'b1;
      pick_queue.push_back(p);
    end else begin
      for (int i = 0; i < k; i++) begin
        p.bits = chain_bits[i];
        p.pos = chain_pos[i];
        p.outcome = OUT_OK;
        p.last = (i == k - 1);
        pick_queue.push_back(p);
      end
    end
    clear_chain();
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    out_tready <= $urandom_range(99) >= recv_idle;
    if (!in_tvalid || in_acc) begin
      if (row_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        sample_t s;
        s = row_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= s.bits;
        in_tlast <= s.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) rank_sample(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (pick_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
      end else begin
        pick_t p;
        p = pick_queue.pop_front();
        if (out_tdata[31:0] != p.bits) report_mismatch("best_bits", out_tdata[31:0], p.bits);
        if (out_tdata[47:32] != p.pos)
          report_mismatch("best_position", 32'(out_tdata[47:32]), 32'(p.pos));
        if (out_tdata[49:48] != p.outcome)
          report_mismatch("outcome", 32'(out_tdata[49:48]), 32'(p.outcome));
        if (out_tlast != p.last)
          report_mismatch("final_of_run", 32'(out_tlast), 32'(p.last));
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    logic [31:0] specials[10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F80_0000,
                                  32'hBF80_0000, 32'h0000_8000, 32'h0000_7F80};
    case ($urandom_range(3))
      0: return specials[$urandom_range(9)];
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'(16'h3F80 + $urandom_range(2))};
      default: return $urandom;
    endcase
  endfunction

  task automatic push_row(int len);
    sample_t s;
    for (int i = 0; i < len; i++) begin
      s.bits = pick_value();
      s.last = (i == len - 1);
      row_queue.push_back(s);
    end
  endtask

  task automatic push_fixed(logic [31:0] b, logic last);
    sample_t s;
    s.bits = b;
    s.last = last;
    row_queue.push_back(s);
  endtask

  task automatic drain();
    while (row_queue.size() != 0 || in_tvalid || pick_queue.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_KEEP) keep_reg = val;
    else fmt_reg = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_block(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int len;
      len = $urandom_range(9) == 0 ? $urandom_range(1, 4) : $urandom_range(1, 20);
      cfg_write(CFG_KEEP, $urandom_range(7) == 0 ? ($urandom_range(1) ? 5'd0 : 5'd31)
                                                 : 5'($urandom_range(1, 16)));
      cfg_write(CFG_FORMAT, 5'($urandom_range(1)));
      push_row(len);
      sent += len;
      drain();
    end
  endtask

  initial begin
    clear_chain();
    keep_reg = 5'd1;
    fmt_reg = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_fixed(32'hFFFF_FFFF, 1'b1);
    push_fixed(32'h8000_0000, 1'b0);
    push_fixed(32'h0000_0000, 1'b1);
    drain();
    cfg_write(CFG_KEEP, 5'd16);
    push_fixed(32'h3F80_0000, 1'b0);
    push_fixed(32'h7F80_0000, 1'b1);
    drain();
    push_fixed(32'h7FC0_0001, 1'b0);
    push_fixed(32'hFF80_0000, 1'b0);
    push_fixed(32'h8000_0000, 1'b0);
    push_fixed(32'h0000_0000, 1'b0);
    push_fixed(32'h7F80_0000, 1'b0);
    push_fixed(32'hFFC0_0000, 1'b0);
    push_fixed(32'h3F80_0000, 1'b0);
    push_fixed(32'h3F80_0000, 1'b0);
    push_fixed(32'hBF80_0000, 1'b0);
    push_fixed(32'h0000_0001, 1'b0);
    push_fixed(32'h807F_FFFF, 1'b0);
    push_fixed(32'h7F7F_FFFF, 1'b0);
    push_fixed(32'hFF7F_FFFF, 1'b0);
    push_fixed(32'h0000_0000, 1'b0);
    push_fixed(32'hFFFF_FFFF, 1'b0);
    push_fixed(32'h5555_AAAA, 1'b1);
    drain();
    cfg_write(CFG_FORMAT, 1'b1);
    cfg_write(CFG_KEEP, 5'd3);
    push_fixed(32'hFFFF_3F80, 1'b0);
    push_fixed(32'h1234_8000, 1'b0);
    push_fixed(32'hABCD_0000, 1'b0);
    push_fixed(32'h0000_7FC1, 1'b1);
    drain();

    random_block(50);
    send_idle = 58;
    recv_idle = 17;
    random_block(50);
    send_idle = 0;
    recv_idle = 0;
    random_block(50);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
